// ----- design/spdb2r_pkg.sv -----
// shared types, constants and tables for the s-parameter format converter
`timescale 1ns / 1ps
package spdb2r_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int GUARD         = 8;
    localparam int CORDIC_STAGES = 16;
    localparam int HORNER_TERMS  = 12;

    // pipeline map: angle reduction and dB exponent share the first stages
    localparam int HORNER_BASE = 2;
    localparam int MAG_IDX     = HORNER_BASE + 2 * HORNER_TERMS;
    localparam int PP_IDX      = MAG_IDX + 1;
    localparam int X0_IDX      = PP_IDX + 1;
    localparam int ROT_IDX     = X0_IDX + 1;
    localparam int LAST_IDX    = ROT_IDX + CORDIC_STAGES - 1;
    localparam int NSTAGE      = LAST_IDX + 1;

    localparam logic signed [61:0] DB_TO_LOG2_Q32 = 62'sd713378626;
    localparam logic [29:0]        LN2_Q30        = 30'd744261118;
    localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
    localparam logic signed [39:0] INV_GAIN_Q22   = 40'sd2547003;
    localparam logic [21:0]        INV_GAIN_U     = 22'd2547003;

    typedef enum logic [1:0] {
        FMT_RE_IM   = 2'd0,
        FMT_MAG_ANG = 2'd1,
        FMT_DB_ANG  = 2'd2,
        FMT_UNUSED  = 2'd3
    } fmt_t;

    typedef struct packed {
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic               saturated;
    } out_beat_t;

    // per-stage payload that rides along the pipe
    typedef struct packed {
        logic [1:0]         fmt;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [29:0]        u;
        logic signed [13:0] n;
        logic signed [32:0] z;
        logic               neg;
        logic               sat;
    } side_t;

    // reciprocals for the horner divisions, terms 12 down to 1
    localparam logic [31:0] RECIP_M [HORNER_TERMS] = '{
        32'd2863311531, 32'd3123612579, 32'd3435973837, 32'd3817748708,
        32'd2147483648, 32'd2454267027, 32'd2863311531, 32'd3435973837,
        32'd2147483648, 32'd2863311531, 32'd2147483648, 32'd2147483648
    };
    localparam int RECIP_SH [HORNER_TERMS] = '{
        35, 35, 35, 35, 34, 34, 34, 34, 33, 33, 32, 31
    };

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic [44:0][12:0] ang_tbl_t;

    // floor(8192 * b / 45) for remainders b of the divide by 45
    function automatic ang_tbl_t make_ang_tbl();
        ang_tbl_t t;
        for (int i = 0; i < 45; i++)
        begin
            t[i] = 13'((i * 8192) / 45);
        end
        return t;
    endfunction

    localparam ang_tbl_t ANG_TBL = make_ang_tbl();

endpackage

// ----- design/sparam_polar_db_to_rectangular_core.sv -----
// s-parameter pair to rectangular converter: angle reduction, dB exponent, cordic
`timescale 1ns / 1ps
//
//  channel   signals                 handshake
//  --------  ----------------------  ------------------------------------------
//  operand   start, busy, operand    beat taken when start && !busy
//  result    done, result            beat shown for one cycle, marked by done
//  config    cfg_we, cfg_wdata       input_format written when cfg_we is high
//
//  fully pipelined: one beat per cycle; the pipe depth is set by the 12-term
//  horner chain for 2^frac (two stages per term) followed by the magnitude,
//  pre-scale and cordic stages
//  busy is held low, the pipe never stalls; the receiver cannot stall either
//  reset clears the valid bits and sets input_format to dB/angle
//  input_format is captured with each beat, so it travels with its data
module sparam_polar_db_to_rectangular_core
    import spdb2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_beat_t  operand,
    input  logic      cfg_we,
    input  logic [1:0] cfg_wdata,
    output logic      done,
    output out_beat_t result
);

    // configuration
    logic [1:0] fmt_reg;

    // valid bits and payload for every stage
    logic  valid_reg  [NSTAGE];
    side_t side_reg   [NSTAGE];
    side_t side_next  [NSTAGE];

    // angle reduction stages
    logic [16:0] hp_reg, hp_next;
    logic [8:0]  qd_reg, qd_next;
    logic [15:0] lo_reg;
    logic [24:0] r_reg, r_next;
    logic [24:0] r2_reg;
    logic [19:0] a45_reg, a45_next;

    // dB exponent and horner chain
    logic signed [61:0] e_reg, e_next;
    logic [30:0] w_reg  [HORNER_TERMS];
    logic [30:0] w_next [HORNER_TERMS];
    logic [30:0] p_reg  [HORNER_TERMS];
    logic [30:0] p_next [HORNER_TERMS];

    // magnitude and gain pre-scale
    logic signed [41:0] mag_reg, mag_next;
    logic [45:0]        pl_reg, pl_next;
    logic signed [39:0] ph_reg, ph_next;
    logic signed [43:0] x0_reg, x0_next;

    // cordic
    logic signed [43:0] cx_reg  [CORDIC_STAGES];
    logic signed [43:0] cy_reg  [CORDIC_STAGES];
    logic signed [32:0] cz_reg  [CORDIC_STAGES];
    logic signed [43:0] cx_next [CORDIC_STAGES];
    logic signed [43:0] cy_next [CORDIC_STAGES];
    logic signed [32:0] cz_next [CORDIC_STAGES];

    // output
    logic      done_reg;
    out_beat_t result_reg, result_next;

    // combinational temporaries
    logic [34:0]        hq_prod;
    logic [16:0]        rem_full;
    logic [50:0]        a45_prod;
    logic [5:0]         b45;
    logic [31:0]        s_u;
    logic signed [32:0] s_s;
    logic [59:0]        u_prod;
    logic [60:0]        w_prod;
    logic [62:0]        q_prod;
    logic [30:0]        p_in;
    logic signed [14:0] sh;
    logic [14:0]        nsh;
    logic signed [63:0] full_prod;
    logic signed [43:0] cx_in, cy_in, dx, dy;
    logic signed [32:0] cz_in;
    logic signed [43:0] xf, yf, xt, yt;
    logic signed [35:0] xr, yr;
    logic               sat_r, sat_i;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_DB_ANG;
        end
        else if (cfg_we)
        begin
            fmt_reg <= cfg_wdata;
        end
    end

    // angle: (deg mod 360) done on the integer degrees, then r * 2^16 / 360
    always_comb
    begin
        hp_next  = 17'({operand.second_value[31], operand.second_value[31:16]}) + 17'd33120;
        hq_prod  = 35'(hp_next) * 35'd186414;
        qd_next  = hq_prod[34:26];
        rem_full = hp_reg - 17'(qd_reg) * 17'd360;
        r_next   = {rem_full[8:0], lo_reg};
        a45_prod = 51'(r_reg) * 51'd47721859;
        a45_next = a45_prod[50:31];
        b45      = 6'(r2_reg - 25'(a45_reg) * 25'd45);
        s_u      = {a45_reg[18:0], 13'b0} + 32'(ANG_TBL[b45]);
        s_s      = 33'($signed(s_u));
    end

    // dB exponent: e = dB * log2(10)/20, u = frac * ln2
    always_comb
    begin
        e_next = 62'(operand.first_value) * DB_TO_LOG2_Q32;
        u_prod = 60'(e_reg[47:18]) * 60'(LN2_Q30);
    end

    // horner terms: multiply stage then divide-by-k stage
    always_comb
    begin
        for (int j = 0; j < HORNER_TERMS; j++)
        begin
            p_in      = (j == 0) ? ONE_Q30 : p_reg[(j == 0) ? 0 : j - 1];
            w_prod    = 61'(side_reg[HORNER_BASE + 2 * j - 1].u) * 61'(p_in);
            w_next[j] = w_prod[60:30];
            q_prod    = 63'(w_reg[j]) * 63'(RECIP_M[j]);
            p_next[j] = ONE_Q30 + 31'(q_prod >> RECIP_SH[j]);
        end
    end

    // stage payload: defaults pass along, a few stages fill in fields
    always_comb
    begin
        side_next[0].fmt = fmt_reg;
        side_next[0].a   = operand.first_value;
        side_next[0].b   = operand.second_value;
        side_next[0].u   = '0;
        side_next[0].n   = '0;
        side_next[0].z   = '0;
        side_next[0].neg = 1'b0;
        side_next[0].sat = 1'b0;
        for (int i = 1; i < NSTAGE; i++)
        begin
            side_next[i] = side_reg[i - 1];
        end

        side_next[1].u = u_prod[59:30];
        side_next[1].n = e_reg[61:48];

        // fold into [-90, 90] degrees, remember the half-turn
        if (s_s > 33'sh0_4000_0000)
        begin
            side_next[3].z   = s_s - 33'sh0_8000_0000;
            side_next[3].neg = 1'b1;
        end
        else if (s_s < -33'sh0_4000_0000)
        begin
            side_next[3].z   = s_s + 33'sh0_8000_0000;
            side_next[3].neg = 1'b1;
        end
        else
        begin
            side_next[3].z   = s_s;
            side_next[3].neg = 1'b0;
        end

        // linear magnitude in guard-bit format
        sh       = $signed({side_reg[MAG_IDX - 1].n[13], side_reg[MAG_IDX - 1].n}) - 15'sd6;
        nsh      = 15'(-sh);
        mag_next = '0;
        if (side_reg[MAG_IDX - 1].fmt == FMT_MAG_ANG)
        begin
            mag_next = {{2{side_reg[MAG_IDX - 1].a[31]}}, side_reg[MAG_IDX - 1].a, 8'b0};
        end
        else if (side_reg[MAG_IDX - 1].fmt == FMT_DB_ANG)
        begin
            if (sh > 15'sd9)
            begin
                // capped at twice the output range
                mag_next = 42'sh100_0000_0000;
                side_next[MAG_IDX].sat = 1'b1;
            end
            else if (sh >= 15'sd0)
            begin
                mag_next = 42'(p_reg[HORNER_TERMS - 1]) << sh[3:0];
            end
            else if (nsh >= 15'd31)
            begin
                mag_next = '0;
            end
            else
            begin
                mag_next = 42'(p_reg[HORNER_TERMS - 1] >> nsh[4:0]);
            end
        end
    end

    // 1/K pre-scale split in two partial products
    always_comb
    begin
        pl_next   = 46'(mag_reg[23:0]) * 46'(INV_GAIN_U);
        ph_next   = 40'($signed(mag_reg[41:24])) * INV_GAIN_Q22;
        full_prod = (64'(ph_reg) <<< 24) + 64'(pl_reg);
        x0_next   = 44'($signed(full_prod[63:22]));
    end

    // cordic rotation stages
    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            cx_in = (i == 0) ? x0_reg : cx_reg[(i == 0) ? 0 : i - 1];
            cy_in = (i == 0) ? 44'sd0 : cy_reg[(i == 0) ? 0 : i - 1];
            cz_in = (i == 0) ? side_reg[X0_IDX].z : cz_reg[(i == 0) ? 0 : i - 1];
            dx    = cy_in >>> i;
            dy    = cx_in >>> i;
            if (cz_in >= 33'sd0)
            begin
                cx_next[i] = cx_in - dx;
                cy_next[i] = cy_in + dy;
                cz_next[i] = cz_in - $signed(33'(ATAN_TURNS[i]));
            end
            else
            begin
                cx_next[i] = cx_in + dx;
                cy_next[i] = cy_in - dy;
                cz_next[i] = cz_in + $signed(33'(ATAN_TURNS[i]));
            end
        end
    end

    // undo the fold, round off guard bits, clamp
    always_comb
    begin
        xf = side_reg[LAST_IDX].neg ? -cx_reg[CORDIC_STAGES - 1] : cx_reg[CORDIC_STAGES - 1];
        yf = side_reg[LAST_IDX].neg ? -cy_reg[CORDIC_STAGES - 1] : cy_reg[CORDIC_STAGES - 1];
        xt = xf + 44'sd128;
        yt = yf + 44'sd128;
        xr = xt[43:8];
        yr = yt[43:8];
        sat_r = (xr > 36'sd2147483647) || (xr < -36'sd2147483648);
        sat_i = (yr > 36'sd2147483647) || (yr < -36'sd2147483648);

        result_next = '0;
        case (side_reg[LAST_IDX].fmt)
            FMT_RE_IM:
            begin
                result_next.real_part = side_reg[LAST_IDX].a;
                result_next.imag_part = side_reg[LAST_IDX].b;
                result_next.saturated = 1'b0;
            end
            FMT_MAG_ANG, FMT_DB_ANG:
            begin
                if (xr > 36'sd2147483647)
                    result_next.real_part = 32'sh7FFF_FFFF;
                else if (xr < -36'sd2147483648)
                    result_next.real_part = 32'sh8000_0000;
                else
                    result_next.real_part = xr[31:0];
                if (yr > 36'sd2147483647)
                    result_next.imag_part = 32'sh7FFF_FFFF;
                else if (yr < -36'sd2147483648)
                    result_next.imag_part = 32'sh8000_0000;
                else
                    result_next.imag_part = yr[31:0];
                result_next.saturated = side_reg[LAST_IDX].sat | sat_r | sat_i;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start;
            for (int i = 1; i < NSTAGE; i++)
            begin
                valid_reg[i] <= valid_reg[i - 1];
            end
            done_reg <= valid_reg[LAST_IDX];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            side_reg[i] <= side_next[i];
        end
        hp_reg  <= hp_next;
        qd_reg  <= qd_next;
        lo_reg  <= operand.second_value[15:0];
        r_reg   <= r_next;
        r2_reg  <= r_reg;
        a45_reg <= a45_next;
        e_reg   <= e_next;
        for (int j = 0; j < HORNER_TERMS; j++)
        begin
            w_reg[j] <= w_next[j];
            p_reg[j] <= p_next[j];
        end
        mag_reg <= mag_next;
        pl_reg  <= pl_next;
        ph_reg  <= ph_next;
        x0_reg  <= x0_next;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            cx_reg[i] <= cx_next[i];
            cy_reg[i] <= cy_next[i];
            cz_reg[i] <= cz_next[i];
        end
        result_reg <= result_next;
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench for the s-parameter pair to rectangular converter core
`timescale 1ns / 1ps
module tb_top
    import spdb2r_pkg::*;
;

    // converter pipe depth, with plenty of margin for the drain
    localparam int PIPE_LAT   = 46;
    localparam int DRAIN_CYC  = 4 * PIPE_LAT;
    localparam int STALL_MAX  = 2000;
    localparam int NUM_RANDOM = 430;

    // arctangent of 2^-i in binary angle units, 2^32 per turn
    localparam longint ATAN_BAM [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_beat_t  operand;
    logic      cfg_we;
    logic [1:0] cfg_wdata;
    logic      done;
    out_beat_t result;

    sparam_polar_db_to_rectangular_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // predictor copy of the format register
    logic [1:0] fmt_shadow;

    out_beat_t pending_rect[$];
    int        err_cnt;
    int        idle_cnt;
    bit        timed_out;

    // arithmetic shift right with floor
    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint sat32(longint v, ref bit clipped);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // 10^(db/20) with guard bits, capped at twice the output range
    function automatic longint db_to_lin(longint db, ref bit capped);
        longint        e;
        longint        n;
        longint        sh;
        logic [63:0]   frac;
        logic [63:0]   f30;
        logic [63:0]   u;
        logic [63:0]   p;
        logic [127:0]  prod;
        e = db * 64'sd713378626;
        n = e >>> (FRAC_BITS + 32);
        frac = e & ((64'd1 << (FRAC_BITS + 32)) - 1);
        f30 = frac >> (FRAC_BITS + 2);
        u = (f30 * 64'd744261118) >> 30;
        p = 64'd1 << 30;
        for (int k = 12; k >= 1; k--)
        begin
            prod = u * p;
            p = (64'd1 << 30) + (64'(prod >> 30)) / 64'(k);
        end
        sh = n + FRAC_BITS + GUARD - 30;
        if (sh > GUARD + 1)
        begin
            capped = 1'b1;
            return 64'sd1 <<< (32 + GUARD);
        end
        if (sh >= 0)
            return longint'(p << sh);
        if (sh <= -63)
            return 0;
        return longint'(p >> (-sh));
    endfunction

    // cordic rotation of a guarded magnitude by an angle in degrees
    function automatic void rotate_deg(longint mag, longint deg,
                                       output longint re, output longint im);
        longint full;
        longint r;
        longint s;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint q;
        bit     flip;
        full = 64'sd360 <<< FRAC_BITS;
        q = 64'sd1 <<< 30;
        flip = 1'b0;
        r = deg % full;
        if (r < 0)
            r += full;
        s = (r * (64'sd1 <<< (32 - FRAC_BITS))) / 360;
        if (s >= (64'sd1 <<< 31))
            s -= 64'sd1 <<< 32;
        if (s > q)
        begin
            s -= 2 * q;
            flip = 1'b1;
        end
        else if (s < -q)
        begin
            s += 2 * q;
            flip = 1'b1;
        end
        x = floor_shr(mag * 64'sd2547003, 22);
        y = 0;
        z = s;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_BAM[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_BAM[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        re = floor_shr(x + (64'sd1 <<< (GUARD - 1)), GUARD);
        im = floor_shr(y + (64'sd1 <<< (GUARD - 1)), GUARD);
    endfunction

    function automatic out_beat_t convert_pair(logic [1:0] fmt, in_beat_t op);
        out_beat_t o;
        longint    a;
        longint    b;
        longint    re;
        longint    im;
        longint    mag;
        bit        clip;
        a = longint'(op.first_value);
        b = longint'(op.second_value);
        re = 0;
        im = 0;
        clip = 1'b0;
        if (fmt == FMT_RE_IM)
        begin
            re = a;
            im = b;
        end
        else if (fmt == FMT_MAG_ANG || fmt == FMT_DB_ANG)
        begin
            if (fmt == FMT_MAG_ANG)
                mag = a <<< GUARD;
            else
                mag = db_to_lin(a, clip);
            rotate_deg(mag, b, re, im);
            re = sat32(re, clip);
            im = sat32(im, clip);
        end
        o.real_part = re[31:0];
        o.imag_part = im[31:0];
        o.saturated = clip;
        return o;
    endfunction

    // result checker: every done beat is compared against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rect.size() == 0)
            begin
                $error("result beat with nothing expected: re %0d im %0d",
                       result.real_part, result.imag_part);
                err_cnt++;
            end
            else
            begin
                out_beat_t exp_b;
                exp_b = pending_rect.pop_front();
                if (result.real_part !== exp_b.real_part)
                begin
                    $error("real_part expected %0d got %0d",
                           exp_b.real_part, result.real_part);
                    err_cnt++;
                end
                if (result.imag_part !== exp_b.imag_part)
                begin
                    $error("imag_part expected %0d got %0d",
                           exp_b.imag_part, result.imag_part);
                    err_cnt++;
                end
                if (result.saturated !== exp_b.saturated)
                begin
                    $error("saturated expected %0b got %0b",
                           exp_b.saturated, result.saturated);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drive one beat; optional typed expectation overrides the predictor
    task automatic send_pair(in_beat_t op, bit gaps, bit has_exp, out_beat_t exp_b);
        out_beat_t pred;
        if (gaps)
        begin
            while ($urandom_range(99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start   <= 1'b1;
        operand <= op;
        pred = convert_pair(fmt_shadow, op);
        if (has_exp && pred !== exp_b)
        begin
            $error("table row disagrees with predictor for %h", op);
            err_cnt++;
        end
        do
            @(posedge clk);
        while (busy);
        pending_rect.insert(pending_rect.size(), has_exp ? exp_b : pred);
    endtask

    // waits for the pipe to empty, then writes the format register
    task automatic set_format(logic [1:0] fmt);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rect.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        cfg_we <= 1'b0;
        fmt_shadow = fmt;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($urandom_range(360 * 65536 - 1));
            2: return 32'($urandom_range(8)) * 32'(45 * 65536);
            default: return -32'($urandom_range(720 * 65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_first(logic [1:0] fmt);
        if ($urandom_range(9) < 2)
            return $urandom();
        if (fmt == FMT_DB_ANG)
            return 32'(int'($urandom_range(260 * 65536)) - 200 * 65536);
        return 32'(int'($urandom_range(4 * 65536 * 1024)) - 2 * 65536 * 1024);
    endfunction

    typedef struct {
        logic [31:0] fv;
        logic [31:0] sv;
        bit          typed;
        out_beat_t   want;
    } dir_row_t;

    initial
    begin
        dir_row_t  rows_db[$];
        dir_row_t  rows_ri[$];
        dir_row_t  rows_ma[$];
        in_beat_t  op;
        logic [1:0] fmt;
        bit        gaps;

        rst_n     = 1'b0;
        start     = 1'b0;
        operand   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = FMT_DB_ANG;
        fmt_shadow = FMT_DB_ANG;
        err_cnt   = 0;
        idle_cnt  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dB/angle right after reset: 0 dB at 0 deg, huge dB capped, tiny dB, +-20 dB, extreme angles
        rows_db = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b0}},
            '{32'h0014_0000, 32'h005A_0000, 1'b0, '0},
            '{32'hFFEC_0000, 32'h00B4_0000, 1'b0, '0},
            '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{32'h0000_0000, 32'h8000_0000, 1'b0, '0}
        };
        foreach (rows_db[i])
        begin
            op.first_value  = rows_db[i].fv;
            op.second_value = rows_db[i].sv;
            send_pair(op, 1'b0, rows_db[i].typed, rows_db[i].want);
        end

        // pass-through: extremes come out untouched
        set_format(FMT_RE_IM);
        rows_ri = '{
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
              '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}}
        };
        foreach (rows_ri[i])
        begin
            op.first_value  = rows_ri[i].fv;
            op.second_value = rows_ri[i].sv;
            send_pair(op, 1'b0, rows_ri[i].typed, rows_ri[i].want);
        end

        // magnitude/angle: quadrant folds, negative magnitude, clamping
        set_format(FMT_MAG_ANG);
        rows_ma = '{
            '{32'h0001_0000, 32'h0000_0000, 1'b0, '0},
            '{32'h0001_0000, 32'h005A_0000, 1'b0, '0},
            '{32'h0001_0000, 32'h00B4_0000, 1'b0, '0},
            '{32'h0001_0000, 32'h010E_0000, 1'b0, '0},
            '{32'h0001_0000, 32'hFF4C_0000, 1'b0, '0},
            '{32'hFFFF_0000, 32'h002D_0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h00B4_0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h002D_0000, 1'b0, '0}
        };
        foreach (rows_ma[i])
        begin
            op.first_value  = rows_ma[i].fv;
            op.second_value = rows_ma[i].sv;
            send_pair(op, 1'b0, rows_ma[i].typed, rows_ma[i].want);
        end

        // unused format code gives zeros
        set_format(FMT_UNUSED);
        op.first_value  = 32'h1234_5678;
        op.second_value = 32'h8765_4321;
        send_pair(op, 1'b0, 1'b1, '{32'd0, 32'd0, 1'b0});

        // random phases; format changes only while drained
        for (int ph = 0; ph < 8; ph++)
        begin
            fmt = (ph == 7) ? FMT_UNUSED : 2'(ph % 3);
            set_format(fmt);
            for (int j = 0; j < NUM_RANDOM / 8; j++)
            begin
                // middle stretch runs back to back with no gaps
                gaps = !(ph == 3);
                op.first_value  = rand_first(fmt);
                op.second_value = (fmt == FMT_RE_IM) ? $urandom() : rand_angle();
                send_pair(op, gaps, 1'b0, '0);
            end
        end
        start <= 1'b0;

        // drain with a cap, then the closing latency
        for (int w = 0; w < 20 * DRAIN_CYC && pending_rect.size() != 0; w++)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
        if (pending_rect.size() != 0)
        begin
            $error("%0d results never arrived", pending_rect.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
